// ----- design/firdec_pkg.sv -----
// Package for the three-axis FIR decimator: request and result types,
// fixed widths, stage constants and the 15-tap coefficient table.
// No dependencies.
package firdec_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COEF_BITS   = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int TAPS        = 15;
  localparam int STAGES      = 2;
  localparam int PHASE_BITS  = 4;
  localparam int OUT_SHIFT   = 19;

  localparam logic [PHASE_BITS-1:0] PHASE_DUE    = PHASE_BITS'(TAPS);
  localparam logic [PHASE_BITS-1:0] STAGE1_START = PHASE_BITS'(8);

  typedef logic signed [SAMPLE_BITS-1:0] sample_word_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    sample_word_t x_sample;
    sample_word_t y_sample;
    sample_word_t z_sample;
  } sample_t;

  typedef struct packed {
    sample_word_t x_out;
    sample_word_t y_out;
    sample_word_t z_out;
  } result_t;

  function automatic coef_t coef_of(input logic [PHASE_BITS-1:0] phase);
    coef_t c;
    case (phase)
      4'd0:    c = 16'sd22504;
      4'd1:    c = 16'sd24378;
      4'd2:    c = 16'sd26033;
      4'd3:    c = 16'sd27436;
      4'd4:    c = 16'sd28559;
      4'd5:    c = 16'sd29378;
      4'd6:    c = 16'sd29877;
      4'd7:    c = 16'sd30044;
      4'd8:    c = 16'sd29877;
      4'd9:    c = 16'sd29378;
      4'd10:   c = 16'sd28559;
      4'd11:   c = 16'sd27436;
      4'd12:   c = 16'sd26033;
      4'd13:   c = 16'sd24378;
      4'd14:   c = 16'sd22504;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/fir_decimator_by8_three_axis_core.sv -----
// Top level of the three-axis FIR decimator by eight (15 taps, two stages).
// Depends on firdec_pkg for types, constants and the coefficient table.
//
// Usage:
//   sample channel (sample, sample_valid, sample_stall) takes one three-axis
//   request per cycle when not stalled; result channel (result, result_valid,
//   result_stall) gives one filtered request for every eight samples accepted.
//   Each accepted sample updates both accumulator stages in the cycle it is
//   taken: one 12x16 multiply and one accumulator add per axis and stage.
//   A stage whose phase reaches 15 loads the result register instead; the
//   result is registered and visible in the cycle after the sample that completed it.
//   Throughput: one sample per cycle, sustained unless a held result stalls the input.
//   Receiver stall: the result register holds; samples that complete no
//   result are still taken, a sample that would complete one waits.
//   Reset (rst, synchronous): stage phases go to 0 and 8, sums to zero,
//   result register empties; sample_stall is high while rst is high.
module fir_decimator_by8_three_axis_core
  import firdec_pkg::*;
#(
  parameter int ACC_BITS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  sample_t sample,
  input  logic    sample_valid,
  output logic    sample_stall,
  output result_t result,
  output logic    result_valid,
  input  logic    result_stall
);

  typedef logic signed [ACC_BITS-1:0] acc_word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  logic [PHASE_BITS-1:0] phase      [STAGES];
  logic [PHASE_BITS-1:0] phase_next [STAGES];
  acc_word_t acc_x [STAGES];
  acc_word_t acc_y [STAGES];
  acc_word_t acc_z [STAGES];
  acc_word_t acc_x_next [STAGES];
  acc_word_t acc_y_next [STAGES];
  acc_word_t acc_z_next [STAGES];
  acc_word_t sh_x [STAGES];
  acc_word_t sh_y [STAGES];
  acc_word_t sh_z [STAGES];
  coef_t     coef [STAGES];
  prod_t     prod_x [STAGES];
  prod_t     prod_y [STAGES];
  prod_t     prod_z [STAGES];

  logic [STAGES-1:0] due;
  logic              accept;
  result_t           emit;

  assign sample_stall = rst | (result_valid & result_stall & (|due));
  assign accept       = sample_valid & ~sample_stall;

  always_comb begin
    emit = '0;
    for (int s = 0; s < STAGES; s++) begin
      due[s]    = (phase[s] == PHASE_DUE);
      coef[s]   = coef_of(phase[s]);
      prod_x[s] = sample.x_sample * coef[s];
      prod_y[s] = sample.y_sample * coef[s];
      prod_z[s] = sample.z_sample * coef[s];
      sh_x[s]   = acc_x[s] >>> OUT_SHIFT;
      sh_y[s]   = acc_y[s] >>> OUT_SHIFT;
      sh_z[s]   = acc_z[s] >>> OUT_SHIFT;
      if (due[s]) begin
        acc_x_next[s] = '0;
        acc_y_next[s] = '0;
        acc_z_next[s] = '0;
        phase_next[s] = '0;
        emit.x_out    = sh_x[s][SAMPLE_BITS-1:0];
        emit.y_out    = sh_y[s][SAMPLE_BITS-1:0];
        emit.z_out    = sh_z[s][SAMPLE_BITS-1:0];
      end else begin
        acc_x_next[s] = acc_x[s] + acc_word_t'(prod_x[s]);
        acc_y_next[s] = acc_y[s] + acc_word_t'(prod_y[s]);
        acc_z_next[s] = acc_z[s] + acc_word_t'(prod_z[s]);
        phase_next[s] = phase[s] + PHASE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase[0] <= '0;
      phase[1] <= STAGE1_START;
      for (int s = 0; s < STAGES; s++) begin
        acc_x[s] <= '0;
        acc_y[s] <= '0;
        acc_z[s] <= '0;
      end
    end else if (accept) begin
      for (int s = 0; s < STAGES; s++) begin
        phase[s] <= phase_next[s];
        acc_x[s] <= acc_x_next[s];
        acc_y[s] <= acc_y_next[s];
        acc_z[s] <= acc_z_next[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && (|due)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (|due)) begin
      result <= emit;
    end
  end

endmodule

// ----- design/firdec_checker.sv -----
// Port-level checker for the three-axis FIR decimator, with its bind.
// Depends on firdec_pkg and the top level fir_decimator_by8_three_axis_core.
module firdec_checker
  import firdec_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input sample_t sample,
  input logic    sample_valid,
  input logic    sample_stall,
  input result_t result,
  input logic    result_valid,
  input logic    result_stall
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result request dropped or changed");

  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample request dropped or changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without a stalled result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_valid && !sample_stall))
    else $error("result request appeared without an accepted sample");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result request present after reset");

endmodule

bind fir_decimator_by8_three_axis_core firdec_checker u_firdec_checker (
  .clk          (clk),
  .rst          (rst),
  .sample       (sample),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

// ----- verif/testbench.sv -----
// Testbench for fir_decimator_by8_three_axis_core: drives sample requests,
// predicts the decimated outputs and checks each accepted result in order.
// Depends on firdec_pkg and the core RTL in design/.
`timescale 1ns / 100ps

module testbench;
  import firdec_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 300;

  localparam sample_word_t WORD_MAX = 12'sd2047;
  localparam sample_word_t WORD_MIN = -12'sd2048;

  class filter_scoreboard;
    int unsigned weight[TAPS];
    logic [PHASE_BITS-1:0] stage_phase[STAGES];
    int stage_sum_x[STAGES];
    int stage_sum_y[STAGES];
    int stage_sum_z[STAGES];
    result_t pending_outputs[$];
    int fails;
    int checked;

    function new();
      weight = '{22504, 24378, 26033, 27436, 28559, 29378, 29877, 30044,
                 29877, 29378, 28559, 27436, 26033, 24378, 22504};
      stage_phase[0] = '0;
      stage_phase[1] = PHASE_BITS'(8);
      for (int s = 0; s < STAGES; s++) begin
        stage_sum_x[s] = 0;
        stage_sum_y[s] = 0;
        stage_sum_z[s] = 0;
      end
      fails = 0;
      checked = 0;
    endfunction

    function void note_sample(sample_t req);
      int sx;
      int sy;
      int sz;
      int w;
      bit due;
      result_t out;
      sx = int'($signed(req.x_sample));
      sy = int'($signed(req.y_sample));
      sz = int'($signed(req.z_sample));
      due = 1'b0;
      out = '0;
      for (int s = 0; s < STAGES; s++) begin
        if (stage_phase[s] < PHASE_BITS'(TAPS)) begin
          w = int'(weight[stage_phase[s]]);
          stage_sum_x[s] += sx * w;
          stage_sum_y[s] += sy * w;
          stage_sum_z[s] += sz * w;
          stage_phase[s] = stage_phase[s] + 1'b1;
        end else begin
          out.x_out = sample_word_t'(stage_sum_x[s] >>> OUT_SHIFT);
          out.y_out = sample_word_t'(stage_sum_y[s] >>> OUT_SHIFT);
          out.z_out = sample_word_t'(stage_sum_z[s] >>> OUT_SHIFT);
          stage_sum_x[s] = 0;
          stage_sum_y[s] = 0;
          stage_sum_z[s] = 0;
          stage_phase[s] = '0;
          due = 1'b1;
        end
      end
      if (due) pending_outputs.push_back(out);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch("result request with none outstanding");
        return;
      end
      want = pending_outputs.pop_front();
      checked++;
      if (got.x_out !== want.x_out)
        report_mismatch($sformatf("x_out %0d, wanted %0d", got.x_out, want.x_out));
      if (got.y_out !== want.y_out)
        report_mismatch($sformatf("y_out %0d, wanted %0d", got.y_out, want.y_out));
      if (got.z_out !== want.z_out)
        report_mismatch($sformatf("z_out %0d, wanted %0d", got.z_out, want.z_out));
    endtask

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic    clk;
  logic    rst;
  sample_t sample;
  logic    sample_valid;
  logic    sample_stall;
  result_t result;
  logic    result_valid;
  logic    result_stall;

  filter_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_off;
  int cycle_count;
  int sent_count;

  fir_decimator_by8_three_axis_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result_stall <= 1'b1;
        hold_off--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  function automatic sample_word_t pick_word();
    case ($urandom_range(15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      default: return sample_word_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample       <= req;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(req);
    sent_count++;
  endtask

  task automatic send_triple(sample_word_t x, sample_word_t y, sample_word_t z);
    sample_t req;
    req.x_sample = x;
    req.y_sample = y;
    req.z_sample = z;
    send_sample(req);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_triple(pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    sb = new();
    cycle_count  = 0;
    sent_count   = 0;
    hold_off     = 0;
    send_idle    = 28;
    recv_idle    = 48;
    rst          = 1'b1;
    sample       = '0;
    sample_valid = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-scale steps, then mixed extremes across the axes
    for (int i = 0; i < 8; i++) send_triple(WORD_MAX, WORD_MAX, WORD_MAX);
    for (int i = 0; i < 8; i++) send_triple(WORD_MIN, WORD_MIN, WORD_MIN);
    for (int i = 0; i < 8; i++) begin
      if (i[0]) send_triple(WORD_MIN, WORD_MAX, -12'sd1);
      else      send_triple(WORD_MAX, WORD_MIN, '0);
    end

    send_random(200);
    // hold the receiver off so the core fills and stalls its input
    hold_off = HOLD_CYCLES;
    send_random(RANDOM_ITEMS / 3 - 200);

    send_idle = 48;
    recv_idle = 28;
    send_random(RANDOM_ITEMS / 3);

    send_idle = 0;
    recv_idle = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    @(negedge clk);
    sample_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d sample requests, checked %0d decimated results", sent_count,
             sb.checked);
    $display("covered full-scale steps, random samples, idle gaps and a long receiver hold");
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- fir_decimator_by8_three_axis_core.f -----
design/firdec_pkg.sv
design/fir_decimator_by8_three_axis_core.sv
design/firdec_checker.sv
verif/testbench.sv
